// ===== rtl/stuffed_frame_receive_parser_assert.svh =====
// ----------------------------------------------------------------------------
// stuffed_frame_receive_parser_assert.svh
// Assertion macros shared by the deframer's checker.
// ----------------------------------------------------------------------------
`ifndef STUFFED_FRAME_RECEIVE_PARSER_ASSERT_SVH
`define STUFFED_FRAME_RECEIVE_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfp_pkg
// Types and constants of the stuffed-frame receive parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

    localparam logic [7:0] FLAG_BYTE   = 8'h7e;
    localparam logic [7:0] ESC_BYTE    = 8'h7d;
    localparam logic [7:0] ESC_MASK    = 8'h20;
    localparam logic [7:0] CTRL_PLAIN  = 8'h00;
    localparam logic [7:0] CTRL_POLL   = 8'h20;
    localparam logic [7:0] TYPE_MAX    = 8'h02;
    localparam logic [7:0] ADDR_RESET  = 8'h03;
    localparam logic [7:0] SEQ_RESET   = 8'hff;

    localparam logic [1:0] PTYPE_DATA    = 2'd0;
    localparam logic [1:0] PTYPE_CONTROL = 2'd1;
    localparam logic [1:0] PTYPE_END     = 2'd2;

    localparam logic [1:0] TLV_LAST = 2'd2;

    // Bytes from the type byte up to the first data byte, type byte included.
    localparam logic [16:0] DATA_HDR_LEN = 17'd4;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ADDR,
        PH_CTRL,
        PH_HCHK,
        PH_TYPE,
        PH_SEQ,
        PH_LENH,
        PH_LENL,
        PH_DATA,
        PH_TLVT,
        PH_TLVL,
        PH_TLVV,
        PH_TRAIL,
        PH_CLOSE
    } t_phase;

    // Classified event passed from front to back.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;   // unescaped packet byte
        logic [1:0]  ptype;  // packet type
        logic        first;  // type byte, restarts position count
        logic [7:0]  seq;    // sequence + 1, for accept of a data packet
    } t_event;

endpackage

`default_nettype wire

// ===== rtl/stuffed_frame_receive_parser.sv =====
// ----------------------------------------------------------------------------
// stuffed_frame_receive_parser
// Byte-stuffed frame deframer: header checks, unescaping, packet parsing,
// trailer check and accept/reject reporting with duplicate detection.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Beat
//  -------   ------------------   ------------------------------------------
//  input     push / full          i_rx_byte: one raw line byte
//  result    empty / pop          kind, payload byte, position, packet type,
//                                 data length, duplicate
//  config    valid / ready        i_cfg_address_byte (ready held high)
//
//  One line byte is taken per cycle; full only rises when the event queue
//  (P_QUEUE_DEPTH entries) is backed up by a stalled result side.
//  A result passes from the front FSM into the queue, then into the back end's
//  output register. Escape bytes and header bytes that pass give none.
//  Reset (synchronous, active low) clears the frame FSM, the queue, the
//  output valid flag, and sets the address to 0x03 and last sequence to 0xff.
//  A stalled pop holds the result; the queue absorbs bytes until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module stuffed_frame_receive_parser
    import sfp_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // line bytes
    input  wire logic        push,
    output      logic        full,
    input  wire logic [7:0]  i_rx_byte,
    // results
    output      logic        empty,
    input  wire logic        pop,
    output      logic [1:0]  o_kind,
    output      logic [7:0]  o_payload_byte,
    output      logic [16:0] o_position,
    output      logic [1:0]  o_packet_type,
    output      logic [15:0] o_data_length,
    output      logic        o_duplicate,
    // address register write
    input  wire logic        valid,
    output      logic        ready,
    input  wire logic [7:0]  i_cfg_address_byte
);

    logic   in_accept;
    logic   ev_valid;
    t_event ev;
    logic   q_full;
    logic   q_valid;
    t_event q_head;
    logic   q_take;

    // The front never needs to wait on anything but queue space.
    assign full      = q_full;
    assign in_accept = push && !q_full;
    assign ready     = 1'b1;

    // Front: per-byte classification and frame state.
    sfp_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (in_accept),
        .i_rx_byte          (i_rx_byte),
        .i_cfg_we           (valid),
        .i_cfg_address_byte (i_cfg_address_byte),
        .o_ev_valid         (ev_valid),
        .o_ev               (ev)
    );

    // Decoupling queue: lets the front keep taking bytes under pop stalls.
    sfp_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (ev_valid),
        .i_wdata (ev),
        .i_rd    (q_take),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rdata (q_head)
    );

    // Back: position count, length, duplicate check, result register.
    sfp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ev_valid     (q_valid),
        .i_ev           (q_head),
        .o_ev_take      (q_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_position     (o_position),
        .o_packet_type  (o_packet_type),
        .o_data_length  (o_data_length),
        .o_duplicate    (o_duplicate)
    );

endmodule

`default_nettype wire

// ===== rtl/sfp_front.sv =====
// ----------------------------------------------------------------------------
// sfp_front
// Frame state machine: header checks, unescaping, check byte, field walk.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_front
    import sfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_address_byte,
    output      logic       o_ev_valid,
    output      t_event     o_ev
);

    t_phase      r_phase, n_phase;
    logic        r_esc, n_esc;
    logic [7:0]  r_hctl, n_hctl;
    logic [7:0]  r_acc, n_acc;
    logic [15:0] r_rem, n_rem;
    logic [7:0]  r_lenh, n_lenh;
    logic [1:0]  r_fc, n_fc;
    logic [1:0]  r_type, n_type;
    logic [7:0]  r_seq, n_seq;
    logic [7:0]  r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_esc   <= 1'b0;
            r_hctl  <= '0;
            r_acc   <= '0;
            r_rem   <= '0;
            r_lenh  <= '0;
            r_fc    <= '0;
            r_type  <= '0;
            r_seq   <= '0;
            r_addr  <= ADDR_RESET;
        end else begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_hctl  <= n_hctl;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
            r_lenh  <= n_lenh;
            r_fc    <= n_fc;
            r_type  <= n_type;
            r_seq   <= n_seq;
            if (i_cfg_we) begin
                r_addr <= i_cfg_address_byte;
            end
        end
    end

    always_comb begin
        logic [7:0] v;
        v          = i_rx_byte;
        n_phase    = r_phase;
        n_esc      = r_esc;
        n_hctl     = r_hctl;
        n_acc      = r_acc;
        n_rem      = r_rem;
        n_lenh     = r_lenh;
        n_fc       = r_fc;
        n_type     = r_type;
        n_seq      = r_seq;
        o_ev_valid = 1'b0;
        o_ev       = '0;
        o_ev.kind  = KIND_REJECT;

        if (i_accept) begin
            case (r_phase)
                PH_IDLE: begin
                    o_ev_valid = (i_rx_byte != FLAG_BYTE);
                    n_phase    = (i_rx_byte == FLAG_BYTE) ? PH_ADDR : PH_IDLE;
                end
                PH_ADDR: begin
                    o_ev_valid = (i_rx_byte != r_addr);
                    n_phase    = (i_rx_byte == r_addr) ? PH_CTRL : PH_IDLE;
                end
                PH_CTRL: begin
                    if (i_rx_byte == CTRL_PLAIN || i_rx_byte == CTRL_POLL) begin
                        n_hctl  = i_rx_byte;
                        n_phase = PH_HCHK;
                    end else begin
                        o_ev_valid = 1'b1;
                        n_phase    = PH_IDLE;
                    end
                end
                PH_HCHK: begin
                    o_ev_valid = (i_rx_byte != (r_addr ^ r_hctl));
                    n_phase    = (i_rx_byte == (r_addr ^ r_hctl)) ? PH_TYPE : PH_IDLE;
                end
                PH_TYPE: begin
                    o_ev_valid = 1'b1;
                    if (i_rx_byte > TYPE_MAX) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_type   = i_rx_byte[1:0];
                        n_acc    = i_rx_byte;
                        n_fc     = '0;
                        o_ev.kind  = KIND_PAYLOAD;
                        o_ev.data  = i_rx_byte;
                        o_ev.ptype = i_rx_byte[1:0];
                        o_ev.first = 1'b1;
                        case (i_rx_byte[1:0])
                            PTYPE_DATA:    n_phase = PH_SEQ;
                            PTYPE_CONTROL: n_phase = PH_TLVT;
                            default:       n_phase = PH_TRAIL;
                        endcase
                    end
                end
                PH_CLOSE: begin
                    o_ev_valid = 1'b1;
                    n_phase    = PH_IDLE;
                    if (i_rx_byte == FLAG_BYTE) begin
                        o_ev.kind  = KIND_ACCEPT;
                        o_ev.ptype = r_type;
                        o_ev.seq   = r_seq;
                    end
                end
                PH_SEQ, PH_LENH, PH_LENL, PH_DATA,
                PH_TLVT, PH_TLVL, PH_TLVV, PH_TRAIL: begin
                    if (!r_esc && i_rx_byte == ESC_BYTE) begin
                        n_esc = 1'b1;
                    end else begin
                        v     = r_esc ? (i_rx_byte ^ ESC_MASK) : i_rx_byte;
                        n_esc = 1'b0;
                        if (r_phase == PH_TRAIL) begin
                            o_ev_valid = (v != r_acc);
                            n_phase    = (v == r_acc) ? PH_CLOSE : PH_IDLE;
                        end else begin
                            n_acc      = r_acc ^ v;
                            o_ev_valid = 1'b1;
                            o_ev.kind  = KIND_PAYLOAD;
                            o_ev.data  = v;
                            o_ev.ptype = r_type;
                            case (r_phase)
                                PH_SEQ: begin
                                    n_seq   = v + 8'd1;
                                    n_phase = PH_LENH;
                                end
                                PH_LENH: begin
                                    n_lenh  = v;
                                    n_phase = PH_LENL;
                                end
                                PH_LENL: begin
                                    n_rem   = {r_lenh, v};
                                    n_phase = ({r_lenh, v} == 16'd0) ? PH_TRAIL : PH_DATA;
                                end
                                PH_DATA: begin
                                    n_rem = r_rem - 16'd1;
                                    if (r_rem == 16'd1) begin
                                        n_phase = PH_TRAIL;
                                    end
                                end
                                PH_TLVT: begin
                                    n_phase = PH_TLVL;
                                end
                                PH_TLVL, PH_TLVV: begin
                                    if (r_phase == PH_TLVL) begin
                                        n_rem = {8'h00, v};
                                    end else begin
                                        n_rem = r_rem - 16'd1;
                                    end
                                    if ((r_phase == PH_TLVL && v != 8'h00)
                                        || (r_phase == PH_TLVV && r_rem != 16'd1)) begin
                                        n_phase = (r_phase == PH_TLVL) ? PH_TLVV : PH_TLVV;
                                    end else if (r_fc >= TLV_LAST) begin
                                        n_phase = PH_TRAIL;
                                    end else begin
                                        n_fc    = r_fc + 2'd1;
                                        n_phase = PH_TLVT;
                                    end
                                end
                                default: begin
                                    n_phase = r_phase;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            // Any rejection or accept clears the per-frame state.
            if (o_ev_valid && o_ev.kind != KIND_PAYLOAD) begin
                n_phase = PH_IDLE;
                n_esc   = 1'b0;
                n_hctl  = '0;
                n_acc   = '0;
                n_rem   = '0;
                n_lenh  = '0;
                n_fc    = '0;
                n_type  = '0;
                n_seq   = '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfp_queue.sv =====
// ----------------------------------------------------------------------------
// sfp_queue
// Small event queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_queue
    import sfp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_wr,
    input  wire t_event i_wdata,
    input  wire logic   i_rd,
    output      logic   o_full,
    output      logic   o_valid,
    output      t_event o_rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_event        r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfp_back.sv =====
// ----------------------------------------------------------------------------
// sfp_back
// Result builder: packet position, data length, duplicate detection,
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_back
    import sfp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_ev_valid,
    input  wire t_event      i_ev,
    output      logic        o_ev_take,
    input  wire logic        i_pop,
    output      logic        o_empty,
    output      logic [1:0]  o_kind,
    output      logic [7:0]  o_payload_byte,
    output      logic [16:0] o_position,
    output      logic [1:0]  o_packet_type,
    output      logic [15:0] o_data_length,
    output      logic        o_duplicate
);

    logic        r_out_valid;
    logic [16:0] r_pos, n_pos;
    logic [7:0]  r_last, n_last;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_byte, n_byte;
    logic [16:0] r_opos, n_opos;
    logic [1:0]  r_type, n_type;
    logic [15:0] r_len, n_len;
    logic        r_dup, n_dup;
    logic [16:0] body_len;

    assign o_ev_take = i_ev_valid && (!r_out_valid || i_pop);
    assign body_len  = r_pos - DATA_HDR_LEN;

    always_comb begin
        n_pos  = r_pos;
        n_last = r_last;
        n_kind = i_ev.kind;
        n_byte = '0;
        n_opos = '0;
        n_type = '0;
        n_len  = '0;
        n_dup  = 1'b0;
        case (i_ev.kind)
            KIND_PAYLOAD: begin
                n_byte = i_ev.data;
                n_type = i_ev.ptype;
                n_opos = i_ev.first ? '0 : r_pos;
                n_pos  = n_opos + 17'd1;
            end
            KIND_ACCEPT: begin
                n_type = i_ev.ptype;
                if (i_ev.ptype == PTYPE_DATA) begin
                    n_len  = body_len[15:0];
                    n_dup  = (i_ev.seq == r_last);
                    n_last = i_ev.seq;
                end
            end
            default: begin
                n_kind = KIND_REJECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_last      <= SEQ_RESET;
        end else begin
            if (o_ev_take) begin
                r_out_valid <= 1'b1;
                r_pos       <= n_pos;
                r_last      <= n_last;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ev_take) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_opos <= n_opos;
            r_type <= n_type;
            r_len  <= n_len;
            r_dup  <= n_dup;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_kind         = r_kind;
    assign o_payload_byte = r_byte;
    assign o_position     = r_opos;
    assign o_packet_type  = r_type;
    assign o_data_length  = r_len;
    assign o_duplicate    = r_dup;

endmodule

`default_nettype wire

// ===== rtl/sfp_checker.sv =====
// ----------------------------------------------------------------------------
// sfp_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stuffed_frame_receive_parser_assert.svh"

module sfp_checker
    import sfp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [1:0]  o_kind,
    input wire logic [7:0]  o_payload_byte,
    input wire logic [16:0] o_position,
    input wire logic [1:0]  o_packet_type,
    input wire logic [15:0] o_data_length,
    input wire logic        o_duplicate
);

    `SFP_ASSERT_NOW(a_kind_legal, i_clk, i_rst_n, !empty, o_kind == KIND_PAYLOAD || o_kind == KIND_ACCEPT || o_kind == KIND_REJECT, "illegal result kind")

    `SFP_ASSERT_NOW(a_non_payload_zero, i_clk, i_rst_n, !empty && o_kind != KIND_PAYLOAD, o_payload_byte == 8'h00 && o_position == 17'd0, "byte or position set on a non-payload result")

    `SFP_ASSERT_NOW(a_reject_clean, i_clk, i_rst_n, !empty && o_kind == KIND_REJECT, o_packet_type == PTYPE_DATA && o_data_length == 16'd0 && !o_duplicate, "reject carries packet fields")

    `SFP_ASSERT_NOW(a_dup_data_accept, i_clk, i_rst_n, !empty && o_duplicate, o_kind == KIND_ACCEPT && o_packet_type == PTYPE_DATA, "duplicate outside data accept")

    `SFP_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_kind) && $stable(o_payload_byte) && $stable(o_position), "result changed while stalled")

endmodule

bind stuffed_frame_receive_parser sfp_checker u_sfp_checker (.*);

`default_nettype wire
